@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CTS_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CTS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// Shared codes and widths for the CDF table sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cts_pkg;

    localparam int RES_W  = 48;
    localparam int DATA_W = 32;
    localparam int DRAW_W = 16;
    localparam int FRAC_W = 16;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_AVG    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef logic [RES_W-1:0] result_t;

endpackage

@@ rtl/core/cts_ram.sv @@
// ----------------------------------------------------------------------------
// cts_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/cts_div.sv @@
// ----------------------------------------------------------------------------
// cts_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cts_div #(
    parameter int DVD_W = 80,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   rem_sh;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[DVS_W-1:0], q_reg[DVD_W-1]};
        if (start)
        begin
            q_next    = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                q_next   = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/core/cdf_table_sampler.sv @@
// ----------------------------------------------------------------------------
// cdf_table_sampler
// Piecewise-linear CDF table with append, inverse-transform sample and mean.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tuser carries the operation, s_tdata the point value,
//   point cdf (Q16.16) and 16-bit uniform draw. One result transfer per
//   input transfer on the output stream: Q32.16 result, points held, and
//   status in m_tuser.
//   Steps, from the input transfer to m_tvalid rising: clear, append and
//   the empty-table error pass through dispatch and the done state.
//   Sample walks the table point by point (RAM read, then compare), and
//   an interpolated sample then waits for the serial divider.
//   Average walks every point the same way, using the shared multiplier.
//   One item is worked at a time; s_tready is low while it runs.
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and its result waits until the receiver takes the first.
//   Reset empties the table and sets the largest cdf to 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdf_table_sampler #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // entry_value, entry_cdf, uniform_draw
    input  logic [79:0]             s_tdata,
    // operation
    input  logic [1:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // result_value, points_held, zero fill
    output logic [((cts_pkg::RES_W + $clog2(TABLE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    output logic [1:0]              m_tuser
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W = ((cts_pkg::RES_W + CW + 7) / 8) * 8;
    localparam int ACC_W = 80;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EV   = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_DST  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_AF1  = 4'd7;
    localparam logic [3:0] S_AF2  = 4'd8;
    localparam logic [3:0] S_AF3  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0] lcdf_reg, lcdf_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        mvld_reg, mvld_next;
    logic        avld_reg;
    logic        mneg_reg, mneg_next;
    logic        aneg_reg;
    logic        ovld_reg, ovld_next;

    logic [1:0]  op_reg, op_next;
    logic [31:0] val_reg, val_next;
    logic [31:0] cdf_reg, cdf_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] c0_reg, c0_next;
    logic [31:0] v0_reg, v0_next;
    logic [32:0] mula_reg, mula_next;
    logic [31:0] mulb_reg, mulb_next;
    logic [64:0] prod_reg;
    logic [31:0] d_reg, d_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    cts_pkg::result_t res_reg, res_next;
    logic [1:0]  st_reg, st_next;
    cts_pkg::result_t ores_reg, ores_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;
    logic [1:0]  ost_reg, ost_next;

    logic        we;
    logic [63:0] rdata;
    logic [31:0] c1, v1;
    logic        last;
    logic [47:0] xprod;
    logic        div_start, div_done;
    logic [79:0] quot;
    logic [ACC_W-2:0] half;
    logic        out_free;

    cts_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata ({val_reg, cdf_reg}),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    cts_div #(.DVD_W(80), .DVS_W(32)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({prod_reg[63:0], 16'b0}),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign c1       = rdata[31:0];
    assign v1       = rdata[63:32];
    assign last     = (CW'(idx_reg) + CW'(1)) == cnt_reg;
    assign xprod    = 48'(s_tdata[79:64]) * 48'(lcdf_reg);
    assign half     = acc_reg[ACC_W-1:1];
    assign out_free = !ovld_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lcdf_next  = lcdf_reg;
        idx_next   = idx_reg;
        mvld_next  = 1'b0;
        mneg_next  = mneg_reg;
        ovld_next  = ovld_reg && !m_tready;
        op_next    = op_reg;
        val_next   = val_reg;
        cdf_next   = cdf_reg;
        x_next     = x_reg;
        c0_next    = c0_reg;
        v0_next    = v0_reg;
        mula_next  = mula_reg;
        mulb_next  = mulb_reg;
        d_next     = d_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        ores_next  = ores_reg;
        ocnt_next  = ocnt_reg;
        ost_next   = ost_reg;
        we         = 1'b0;
        div_start  = 1'b0;

        if (avld_reg)
        begin
            if (aneg_reg)
            begin
                acc_next = acc_reg - ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    val_next   = s_tdata[31:0];
                    cdf_next   = s_tdata[63:32];
                    x_next     = xprod[47:16];
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_next  = '0;
                st_next   = cts_pkg::ST_OK;
                idx_next  = '0;
                c0_next   = '0;
                v0_next   = '0;
                acc_next  = '0;
                state_next = S_DONE;
                case (op_reg)
                    cts_pkg::OP_CLEAR:
                    begin
                        cnt_next  = '0;
                        lcdf_next = cts_pkg::ONE_Q16;
                    end
                    cts_pkg::OP_APPEND:
                    begin
                        if (cnt_reg == CW'(TABLE_DEPTH))
                        begin
                            st_next = cts_pkg::ST_FULL;
                        end
                        else
                        begin
                            we       = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                            if (cdf_reg > lcdf_reg)
                            begin
                                lcdf_next = cdf_reg;
                            end
                        end
                    end
                    default:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = cts_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                if (op_reg == cts_pkg::OP_AVG)
                begin
                    mvld_next = 1'b1;
                    mula_next = 33'(v0_reg) + 33'(v1);
                    mneg_next = c1 < c0_reg;
                    mulb_next = (c1 < c0_reg) ? (c0_reg - c1) : (c1 - c0_reg);
                    c0_next   = c1;
                    v0_next   = v1;
                    idx_next  = idx_reg + AW'(1);
                    state_next = last ? S_AF1 : S_RD;
                end
                else if (x_reg > c1)
                begin
                    c0_next  = c1;
                    v0_next  = v1;
                    idx_next = idx_reg + AW'(1);
                    if (last)
                    begin
                        res_next   = {v1, 16'b0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
                else if (c0_reg == c1)
                begin
                    res_next   = {33'(v0_reg) + 33'(v1), 15'b0};
                    state_next = S_DONE;
                end
                else if (c1 < c0_reg || x_reg < c0_reg)
                begin
                    res_next   = {v0_reg, 16'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    mula_next  = {1'b0, x_reg - c0_reg};
                    mneg_next  = v1 < v0_reg;
                    mulb_next  = (v1 < v0_reg) ? (v0_reg - v1) : (v1 - v0_reg);
                    d_next     = c1 - c0_reg;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DST;
            end
            S_DST:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (mneg_reg)
                    begin
                        res_next = {v0_reg, 16'b0} - quot[47:0];
                    end
                    else
                    begin
                        res_next = {v0_reg, 16'b0} + quot[47:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_AF1:
            begin
                state_next = S_AF2;
            end
            S_AF2:
            begin
                state_next = S_AF3;
            end
            S_AF3:
            begin
                if (acc_reg[ACC_W-1])
                begin
                    res_next = '0;
                end
                else if (half[ACC_W-2:cts_pkg::RES_W] != '0)
                begin
                    res_next = '1;
                end
                else
                begin
                    res_next = half[cts_pkg::RES_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    ores_next  = res_reg;
                    ocnt_next  = cnt_reg;
                    ost_next   = st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            lcdf_reg  <= cts_pkg::ONE_Q16;
            idx_reg   <= '0;
            mvld_reg  <= 1'b0;
            avld_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lcdf_reg  <= lcdf_next;
            idx_reg   <= idx_next;
            mvld_reg  <= mvld_next;
            avld_reg  <= mvld_reg;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mneg_reg <= mneg_next;
        aneg_reg <= mneg_reg;
        op_reg   <= op_next;
        val_reg  <= val_next;
        cdf_reg  <= cdf_next;
        x_reg    <= x_next;
        c0_reg   <= c0_next;
        v0_reg   <= v0_next;
        mula_reg <= mula_next;
        mulb_reg <= mulb_next;
        prod_reg <= 65'(mula_reg) * 65'(mulb_reg);
        d_reg    <= d_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        ores_reg <= ores_next;
        ocnt_reg <= ocnt_next;
        ost_reg  <= ost_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = OUT_W'({ocnt_reg, ores_reg});
    assign m_tuser  = ost_reg;

    `CTS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input taken while an item is in progress")
    `CTS_ASSERT(a_full_count, clk, rst_n,
        !(m_tvalid && m_tuser == cts_pkg::ST_FULL) || ocnt_reg == CW'(TABLE_DEPTH),
        "table full reported with room left")
    `CTS_ASSERT(a_empty_zero, clk, rst_n,
        !(m_tvalid && m_tuser == cts_pkg::ST_EMPTY) || (ocnt_reg == '0 && ores_reg == '0),
        "empty status with nonzero result or count")
    `CTS_ASSERT(a_div_in_state, clk, rst_n, !div_done || state_reg == S_DIV,
        "divider finished outside its wait state")

endmodule

@@ sim/cdf_table_sampler_tb.sv @@
// ----------------------------------------------------------------------------
// cdf_table_sampler_tb
// Stream-level check of the CDF table sampler. A directed table covers the
// empty, extreme and special interpolation cases, and a fill run the full
// table; random phases build small tables and draw samples and averages.
// Every result is compared field by field with an in-bench model of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cdf_table_sampler_tb;

    localparam int DEPTH       = 1024;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MDATA_W     = ((cts_pkg::RES_W + CNT_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 300;
    localparam logic [47:0] RES_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic [31:0] cdf;
        logic [15:0] draw;
    } req_t;

    typedef struct packed {
        logic [47:0]      res;
        logic [CNT_W-1:0] held;
        logic [1:0]       status;
    } rsp_t;

    typedef struct {
        req_t req;
        logic known;
        rsp_t rsp;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [79:0]        s_tdata;
    logic [1:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [MDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    logic [31:0] tbl_value [DEPTH];
    logic [31:0] tbl_cdf [DEPTH];
    int unsigned tbl_count;
    logic [31:0] tbl_peak;

    rsp_t        pending_q[$];
    int unsigned mismatches;
    int unsigned stall_long;
    int unsigned hold_cnt;
    bit          hold_rx;
    row_t        rows[$];

    cdf_table_sampler #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [47:0] sample_of(logic [15:0] u);
        logic [63:0] x;
        logic [63:0] c0, c1, v0, v1, d, num, q, r, delta;
        x = (64'(u) * 64'(tbl_peak)) >> 16;
        for (int i = 0; i < tbl_count; i++)
        begin
            c1 = tbl_cdf[i];
            v1 = tbl_value[i];
            c0 = 0;
            v0 = 0;
            if (x > c1)
                continue;
            if (i > 0)
            begin
                c0 = tbl_cdf[i-1];
                v0 = tbl_value[i-1];
            end
            if (c0 == c1)
                return 48'((v0 + v1) << 15);
            if (c1 < c0 || x < c0)
                return 48'(v0 << 16);
            d = c1 - c0;
            num = (x - c0) * (v1 >= v0 ? v1 - v0 : v0 - v1);
            q = num / d;
            r = num % d;
            delta = (q << 16) + ((r << 16) / d);
            return (v1 >= v0) ? 48'((v0 << 16) + delta) : 48'((v0 << 16) - delta);
        end
        return {tbl_value[tbl_count-1], 16'd0};
    endfunction

    function automatic logic [47:0] mean_of();
        logic signed [127:0] acc;
        logic [63:0] c0, v0;
        acc = 0;
        for (int i = 0; i < tbl_count; i++)
        begin
            c0 = (i > 0) ? tbl_cdf[i-1] : 0;
            v0 = (i > 0) ? tbl_value[i-1] : 0;
            acc += $signed(128'(v0 + tbl_value[i]))
                 * ($signed(128'(tbl_cdf[i])) - $signed(128'(c0)));
        end
        if (acc < 0)
            return 48'd0;
        acc = acc >>> 1;
        if (acc > $signed(128'(RES_MAX)))
            return RES_MAX;
        return acc[47:0];
    endfunction

    function automatic rsp_t predict(req_t r);
        rsp_t o;
        o = '0;
        case (r.op)
            cts_pkg::OP_CLEAR:
            begin
                tbl_count = 0;
                tbl_peak = cts_pkg::ONE_Q16;
            end
            cts_pkg::OP_APPEND:
            begin
                if (tbl_count >= DEPTH)
                    o.status = cts_pkg::ST_FULL;
                else
                begin
                    tbl_value[tbl_count] = r.value;
                    tbl_cdf[tbl_count] = r.cdf;
                    if (r.cdf > tbl_peak)
                        tbl_peak = r.cdf;
                    tbl_count++;
                end
            end
            default:
            begin
                if (tbl_count == 0)
                    o.status = cts_pkg::ST_EMPTY;
                else if (r.op == cts_pkg::OP_SAMPLE)
                    o.res = sample_of(r.draw);
                else
                    o.res = mean_of();
            end
        endcase
        o.held = CNT_W'(tbl_count);
        return o;
    endfunction

    // waits for the edge at which the offered item is taken
    task automatic wait_accept();
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    task automatic send(req_t r, logic known = 1'b0, rsp_t want = '0);
        rsp_t p;
        int gap;
        p = predict(r);
        if (known && p != want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with model: row %h model %h", want, p);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {r.draw, r.cdf, r.value};
        wait_accept();
        pending_q.push_back(p);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 300);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t mk(logic [1:0] op, logic [31:0] v, logic [31:0] c,
                                logic [15:0] u);
        req_t r;
        r.op = op;
        r.value = v;
        r.cdf = c;
        r.draw = u;
        return r;
    endfunction

    // receiver: random stalls, one long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_long <= 0;
            hold_cnt <= 0;
        end
        else
        begin
            if (!hold_rx)
                hold_cnt <= 0;
            if (hold_rx && hold_cnt < HOLD_CYCLES)
            begin
                hold_cnt <= hold_cnt + 1;
                m_tready <= 1'b0;
            end
            else if (stall_long != 0)
            begin
                stall_long <= stall_long - 1;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                stall_long <= $urandom_range(10, 60);
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        rsp_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.res = m_tdata[47:0];
            got.held = m_tdata[48 +: CNT_W];
            got.status = m_tuser;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %h", got);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: res %h/%h held %0d/%0d status %0d/%0d",
                                 want.res, got.res, want.held, got.held,
                                 want.status, got.status);
                end
            end
        end
    end

    initial
    begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int n, k;
        logic [31:0] c;
        rsp_t w;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = cts_pkg::OP_CLEAR;
        rst_n = 1'b0;
        hold_rx = 1'b0;
        mismatches = 0;
        tbl_count = 0;
        tbl_peak = cts_pkg::ONE_Q16;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        w = '0; w.status = cts_pkg::ST_EMPTY;
        rows.push_back('{mk(cts_pkg::OP_SAMPLE, 0, 0, 16'hFFFF), 1'b1, w});
        rows.push_back('{mk(cts_pkg::OP_AVG, 0, 0, 0), 1'b1, w});
        w = '0; w.held = 1;
        rows.push_back('{mk(cts_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h0001_0000, 0), 1'b1, w});
        rows.push_back('{mk(cts_pkg::OP_SAMPLE, 0, 0, 16'hFFFF), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_SAMPLE, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_AVG, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_APPEND, 7, 32'h0001_0000, 0), 1'b0, '0});  // equal cdf
        rows.push_back('{mk(cts_pkg::OP_SAMPLE, 0, 0, 16'hFFFF), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_APPEND, 3, 32'h0000_8000, 0), 1'b0, '0});  // falling cdf
        rows.push_back('{mk(cts_pkg::OP_SAMPLE, 0, 0, 16'h4000), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_AVG, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_APPEND, 0, 32'hFFFF_FFFF, 0), 1'b0, '0});  // falling value
        rows.push_back('{mk(cts_pkg::OP_SAMPLE, 0, 0, 16'hFFFF), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_SAMPLE, 0, 0, 16'h8001), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_AVG, 0, 0, 0), 1'b0, '0});
        w = '0;
        rows.push_back('{mk(cts_pkg::OP_CLEAR, 0, 0, 0), 1'b1, w});
        rows.push_back('{mk(cts_pkg::OP_APPEND, 5, 32'h0000_2000, 0), 1'b0, '0});  // no match
        rows.push_back('{mk(cts_pkg::OP_SAMPLE, 0, 0, 16'hFFFF), 1'b0, '0});
        rows.push_back('{mk(cts_pkg::OP_APPEND, 32'hFFFF_FFFF, 0, 0), 1'b0, '0}); // negative mean
        rows.push_back('{mk(cts_pkg::OP_AVG, 0, 0, 0), 1'b0, '0});
        foreach (rows[i])
            send(rows[i].req, rows[i].known, rows[i].rsp);
        drain();

        // fill to the limit, then one over
        send(mk(cts_pkg::OP_CLEAR, 0, 0, 0));
        for (int i = 0; i < DEPTH; i++)
        begin
            s_tvalid <= 1'b1;
            s_tuser <= cts_pkg::OP_APPEND;
            s_tdata <= {16'd0, 32'(i * 64), 32'(i)};
            void'(predict(mk(cts_pkg::OP_APPEND, 32'(i), 32'(i * 64), 0)));
            wait_accept();
            w = '0; w.held = CNT_W'(i + 1);
            pending_q.push_back(w);
        end
        w = '0; w.held = CNT_W'(DEPTH); w.status = cts_pkg::ST_FULL;
        send(mk(cts_pkg::OP_APPEND, 1, 1, 0), 1'b1, w);
        send(mk(cts_pkg::OP_SAMPLE, 0, 0, 16'hFFFF));
        send(mk(cts_pkg::OP_AVG, 0, 0, 0));
        drain();

        // receiver holds off while the sender keeps offering
        hold_rx <= 1'b1;
        send(mk(cts_pkg::OP_CLEAR, 0, 0, 0));
        for (int i = 0; i < 4; i++)
            send(mk(cts_pkg::OP_APPEND, rnd32(), rnd32(), 0));
        hold_rx <= 1'b0;
        drain();

        // random phases: build a small table, then draw from it
        n = 0;
        while (n < 540)
        begin
            send(mk(cts_pkg::OP_CLEAR, 0, 0, 0));
            n++;
            k = $urandom_range(1, 12);
            c = 0;
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    c = rnd32();
                else
                    c = c + $urandom_range(0, 1 << $urandom_range(0, 20));
                send(mk(cts_pkg::OP_APPEND, rnd32(), c, $urandom));
                n++;
            end
            for (int i = 0; i < 8; i++)
            begin
                send(mk($urandom_range(0, 5) == 0 ? cts_pkg::OP_AVG : cts_pkg::OP_SAMPLE,
                        $urandom, $urandom, $urandom));
                n++;
            end
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        drain();
        repeat (3000) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
